>>> src/qsfj_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants of the quad shape function / Jacobian block.
package qsfj_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int COORD_W       = 32;
   localparam int DERIV_W       = 32;
   localparam int JAC_W         = 48;
   localparam int SHAPE_W       = 17;
   localparam int NODE_W        = 2;
   localparam int WIDE_W        = 64;
   localparam int QUO_W         = 32;
   localparam int GRAD_W        = 34;

   localparam logic [NODE_W-1:0] LAST_NODE = 2'd3;

   // round(2^f / sqrt(3)) by integer square root
   function automatic longint unsigned inv_sqrt3(input int unsigned f);
      longint unsigned four_f;
      longint unsigned t;
      longint unsigned n;
      longint unsigned c;
      four_f = 64'd1 << (2 * f);
      t      = four_f / 64'd3;
      n      = 64'd0;
      for (int i = 25; i >= 0; i--) begin
         c = n | (64'd1 << i);
         if (c * c <= t) begin
            n = c;
         end
      end
      if (64'd3 * (64'd2 * n + 64'd1) * (64'd2 * n + 64'd1) < (four_f << 2)) begin
         n = n + 64'd1;
      end
      return n;
   endfunction

   localparam longint unsigned G16 = inv_sqrt3(16);
   localparam longint unsigned S16 = 64'd65536;
   localparam logic [SHAPE_W-1:0] SHP_PP =
      SHAPE_W'(((S16 + G16) * (S16 + G16) + 64'd131072) >> 18);
   localparam logic [SHAPE_W-1:0] SHP_PM =
      SHAPE_W'(((S16 + G16) * (S16 - G16) + 64'd131072) >> 18);
   localparam logic [SHAPE_W-1:0] SHP_MM =
      SHAPE_W'(((S16 - G16) * (S16 - G16) + 64'd131072) >> 18);

   localparam logic [DERIV_W-1:0] DERIV_MAX = {1'b0, {(DERIV_W-1){1'b1}}};
   localparam logic [DERIV_W-1:0] DERIV_MIN = {1'b1, {(DERIV_W-1){1'b0}}};
   localparam logic [JAC_W-1:0]   JAC_MAX   = {1'b0, {(JAC_W-1){1'b1}}};
   localparam logic [JAC_W-1:0]   JAC_MIN   = {1'b1, {(JAC_W-1){1'b0}}};

   typedef struct packed {
      logic                     valid;
      logic [NODE_W-1:0]        node;
      logic [SHAPE_W-1:0]       shape;
      logic signed [WIDE_W-1:0] jac;
      logic signed [WIDE_W-1:0] nx;
      logic signed [WIDE_W-1:0] ny;
   } front_word_type;

   typedef struct packed {
      logic               valid;
      logic [NODE_W-1:0]  node;
      logic [SHAPE_W-1:0] shape;
      logic [JAC_W-1:0]   jac;
      logic               degen;
   } side_type;

   // signed, saturated quotient from rounded magnitude, sign and overflow
   function automatic logic [DERIV_W-1:0] sat_quot(input logic [QUO_W-1:0] q,
                                                   input logic neg, input logic ovf);
      logic [DERIV_W-1:0] r;
      if (!neg) begin
         r = (ovf || q[QUO_W-1]) ? DERIV_MAX : q;
      end else begin
         r = (ovf || (q[QUO_W-1] && (|q[QUO_W-2:0]))) ? DERIV_MIN : (~q + 32'd1);
      end
      return r;
   endfunction

   function automatic logic [JAC_W-1:0] sat_jac(input logic signed [WIDE_W-1:0] j);
      logic [JAC_W-1:0] r;
      if (!j[WIDE_W-1] && (|j[WIDE_W-2:JAC_W-1])) begin
         r = JAC_MAX;
      end else if (j[WIDE_W-1] && !(&j[WIDE_W-2:JAC_W-1])) begin
         r = JAC_MIN;
      end else begin
         r = j[JAC_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> src/qsfj_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: rounded quotient magnitude, one bit per stage.
module qsfj_div (
   input  logic                                 clock,
   input  logic                                 adv,
   input  logic signed [qsfj_pkg::WIDE_W-1:0]   num,
   input  logic signed [qsfj_pkg::WIDE_W-1:0]   den,
   output logic        [qsfj_pkg::QUO_W-1:0]    quot,
   output logic                                 neg,
   output logic                                 ovf
);
   localparam int WW = qsfj_pkg::WIDE_W;
   localparam int QW = qsfj_pkg::QUO_W;

   logic [WW-1:0] un;
   logic [WW-1:0] ud;
   logic [WW-1:0] n2;
   logic [WW-1:0] d2;
   logic          ovf_in;

   logic [WW-1:0] r_ff   [0:QW];
   logic [QW-1:0] low_ff [0:QW];
   logic [WW-1:0] d_ff   [0:QW];
   logic [QW-1:0] q_ff   [0:QW];
   logic          neg_ff [0:QW];
   logic          ovf_ff [0:QW];

   logic [WW:0]   trial  [1:QW];
   logic          ge     [1:QW];

   always_comb begin
      un     = num[WW-1] ? (~num + 64'd1) : num;
      ud     = den[WW-1] ? (~den + 64'd1) : den;
      n2     = (un << 1) + ud;
      d2     = ud << 1;
      ovf_in = {{(WW-QW){1'b0}}, n2[WW-1:QW]} >= d2;
      for (int k = 1; k <= QW; k++) begin
         trial[k] = {r_ff[k-1], low_ff[k-1][QW-1]};
         ge[k]    = trial[k] >= {1'b0, d_ff[k-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0]   <= {{(WW-QW){1'b0}}, n2[WW-1:QW]};
         low_ff[0] <= n2[QW-1:0];
         d_ff[0]   <= d2;
         q_ff[0]   <= '0;
         neg_ff[0] <= num[WW-1] ^ den[WW-1];
         ovf_ff[0] <= ovf_in;
         for (int k = 1; k <= QW; k++) begin
            r_ff[k]   <= ge[k] ? WW'(trial[k] - {1'b0, d_ff[k-1]}) : trial[k][WW-1:0];
            low_ff[k] <= low_ff[k-1] << 1;
            d_ff[k]   <= d_ff[k-1];
            q_ff[k]   <= {q_ff[k-1][QW-2:0], ge[k]};
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quot = q_ff[QW];
   assign neg  = neg_ff[QW];
   assign ovf  = ovf_ff[QW];
endmodule

>>> src/qsfj_front.sv
`timescale 1ns / 1ps
// Node expander and geometry pipeline: gradients, Jacobian, numerators, shape.
module qsfj_front #(
   parameter int FRAC_BITS = qsfj_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_quad_point,
   input  logic signed [qsfj_pkg::COORD_W-1:0]  req_node_x0,
   input  logic signed [qsfj_pkg::COORD_W-1:0]  req_node_y0,
   input  logic signed [qsfj_pkg::COORD_W-1:0]  req_node_x1,
   input  logic signed [qsfj_pkg::COORD_W-1:0]  req_node_y1,
   input  logic signed [qsfj_pkg::COORD_W-1:0]  req_node_x2,
   input  logic signed [qsfj_pkg::COORD_W-1:0]  req_node_y2,
   input  logic signed [qsfj_pkg::COORD_W-1:0]  req_node_x3,
   input  logic signed [qsfj_pkg::COORD_W-1:0]  req_node_y3,
   output qsfj_pkg::front_word_type             front_word
);
   localparam int XW = qsfj_pkg::COORD_W;
   localparam int DFW = XW + 1;
   localparam int CW = FRAC_BITS + 2;
   localparam int PW = DFW + CW;
   localparam int SW = PW + 2;
   localparam int DW = qsfj_pkg::GRAD_W;
   localparam int RS = FRAC_BITS + 2;
   localparam int NW = DW + CW + 1;
   localparam int JW = 2 * DW;
   localparam int WW = qsfj_pkg::WIDE_W;
   localparam int NODEW = qsfj_pkg::NODE_W;

   localparam longint unsigned S_VAL = 64'd1 << FRAC_BITS;
   localparam longint unsigned G_VAL = qsfj_pkg::inv_sqrt3(FRAC_BITS);
   localparam logic signed [CW-1:0] C_PLUS  = CW'(S_VAL + G_VAL);
   localparam logic signed [CW-1:0] C_MINUS = CW'(S_VAL - G_VAL);
   localparam logic signed [SW-1:0] RND3 = SW'(1) << (FRAC_BITS + 1);
   localparam logic signed [WW-1:0] RND5 = WW'(1) << (FRAC_BITS - 1);

   // item holding register and node counter
   logic [1:0]             qp_ff;
   logic signed [XW-1:0]   x_ff [0:3];
   logic signed [XW-1:0]   y_ff [0:3];
   logic [NODEW-1:0]       cnt_ff;
   logic                   busy_ff;
   logic                   accept;
   logic                   sxi_pos;
   logic                   seta_pos;

   logic                   v1_ff, v2_ff, v3_ff, v4_ff;
   logic [NODEW-1:0]       node1_ff, node2_ff, node3_ff, node4_ff;
   logic                   sxi1_ff, sxi2_ff, sxi3_ff, sxi4_ff;
   logic                   seta1_ff, seta2_ff, seta3_ff, seta4_ff;

   logic signed [DFW-1:0]  xd_ff [0:3];
   logic signed [DFW-1:0]  yd_ff [0:3];
   logic signed [PW-1:0]   px_ff [0:3];
   logic signed [PW-1:0]   py_ff [0:3];
   logic signed [DW-1:0]   dxx_ff, dxe_ff, dyx_ff, dye_ff;
   logic signed [CW:0]     cxi_ff, ceta_ff;
   logic signed [WW-1:0]   pj1_ff, pj2_ff;
   logic signed [NW-1:0]   pnx1_ff, pnx2_ff, pny1_ff, pny2_ff;
   qsfj_pkg::front_word_type front_ff;

   logic signed [CW-1:0]   fe_low, fe_high, fx_a, fx_b;
   logic signed [CW:0]     cxi_in, ceta_in;
   logic signed [SW-1:0]   sxx, sxe, syx, sye;
   logic signed [JW-1:0]   pj1_full, pj2_full;
   logic signed [WW-1:0]   jr1, jr2;
   logic signed [NW:0]     nx_w, ny_w;
   logic                   plus_x, plus_e;
   logic [qsfj_pkg::SHAPE_W-1:0] shape_in;

   assign req_stall = busy_ff && !(adv && cnt_ff == qsfj_pkg::LAST_NODE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      sxi_pos  = qp_ff inside {2'd0, 2'd3};
      seta_pos = qp_ff inside {2'd0, 2'd1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (accept) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (adv && busy_ff) begin
         cnt_ff <= cnt_ff + 2'd1;
         if (cnt_ff == qsfj_pkg::LAST_NODE) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         qp_ff   <= req_quad_point;
         x_ff[0] <= req_node_x0;
         y_ff[0] <= req_node_y0;
         x_ff[1] <= req_node_x1;
         y_ff[1] <= req_node_y1;
         x_ff[2] <= req_node_x2;
         y_ff[2] <= req_node_y2;
         x_ff[3] <= req_node_x3;
         y_ff[3] <= req_node_y3;
      end
   end

   // coefficients (S +/- G) by corner side and Gauss point sign
   always_comb begin
      fe_low  = seta1_ff ? C_MINUS : C_PLUS;
      fe_high = seta1_ff ? C_PLUS  : C_MINUS;
      fx_a    = sxi1_ff  ? C_MINUS : C_PLUS;
      fx_b    = sxi1_ff  ? C_PLUS  : C_MINUS;
   end

   always_comb begin
      case (node2_ff)
         2'd0: begin
            cxi_in  = -(CW+1)'(seta2_ff ? C_MINUS : C_PLUS);
            ceta_in = -(CW+1)'(sxi2_ff  ? C_MINUS : C_PLUS);
         end
         2'd1: begin
            cxi_in  =  (CW+1)'(seta2_ff ? C_MINUS : C_PLUS);
            ceta_in = -(CW+1)'(sxi2_ff  ? C_PLUS  : C_MINUS);
         end
         2'd2: begin
            cxi_in  =  (CW+1)'(seta2_ff ? C_PLUS  : C_MINUS);
            ceta_in =  (CW+1)'(sxi2_ff  ? C_PLUS  : C_MINUS);
         end
         default: begin
            cxi_in  = -(CW+1)'(seta2_ff ? C_PLUS  : C_MINUS);
            ceta_in =  (CW+1)'(sxi2_ff  ? C_MINUS : C_PLUS);
         end
      endcase
   end

   always_comb begin
      sxx = SW'(px_ff[0]) + SW'(px_ff[1]) + RND3;
      sxe = SW'(px_ff[2]) + SW'(px_ff[3]) + RND3;
      syx = SW'(py_ff[0]) + SW'(py_ff[1]) + RND3;
      sye = SW'(py_ff[2]) + SW'(py_ff[3]) + RND3;
      pj1_full = JW'(dxx_ff) * JW'(dye_ff);
      pj2_full = JW'(dxe_ff) * JW'(dyx_ff);
      jr1  = (pj1_ff + RND5) >>> FRAC_BITS;
      jr2  = (pj2_ff + RND5) >>> FRAC_BITS;
      nx_w = (NW+1)'(pnx1_ff) - (NW+1)'(pnx2_ff);
      ny_w = (NW+1)'(pny1_ff) - (NW+1)'(pny2_ff);
      plus_x = (node4_ff == 2'd1 || node4_ff == 2'd2) ? sxi4_ff : !sxi4_ff;
      plus_e = (node4_ff == 2'd2 || node4_ff == 2'd3) ? seta4_ff : !seta4_ff;
      if (plus_x && plus_e) begin
         shape_in = qsfj_pkg::SHP_PP;
      end else if (plus_x || plus_e) begin
         shape_in = qsfj_pkg::SHP_PM;
      end else begin
         shape_in = qsfj_pkg::SHP_MM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         v4_ff          <= 1'b0;
         front_ff.valid <= 1'b0;
      end else if (adv) begin
         v1_ff          <= busy_ff;
         v2_ff          <= v1_ff;
         v3_ff          <= v2_ff;
         v4_ff          <= v3_ff;
         front_ff.valid <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         node1_ff <= cnt_ff;
         sxi1_ff  <= sxi_pos;
         seta1_ff <= seta_pos;
         xd_ff[0] <= DFW'(x_ff[1]) - DFW'(x_ff[0]);
         xd_ff[1] <= DFW'(x_ff[2]) - DFW'(x_ff[3]);
         xd_ff[2] <= DFW'(x_ff[3]) - DFW'(x_ff[0]);
         xd_ff[3] <= DFW'(x_ff[2]) - DFW'(x_ff[1]);
         yd_ff[0] <= DFW'(y_ff[1]) - DFW'(y_ff[0]);
         yd_ff[1] <= DFW'(y_ff[2]) - DFW'(y_ff[3]);
         yd_ff[2] <= DFW'(y_ff[3]) - DFW'(y_ff[0]);
         yd_ff[3] <= DFW'(y_ff[2]) - DFW'(y_ff[1]);

         node2_ff <= node1_ff;
         sxi2_ff  <= sxi1_ff;
         seta2_ff <= seta1_ff;
         px_ff[0] <= PW'(xd_ff[0]) * PW'(fe_low);
         px_ff[1] <= PW'(xd_ff[1]) * PW'(fe_high);
         px_ff[2] <= PW'(xd_ff[2]) * PW'(fx_a);
         px_ff[3] <= PW'(xd_ff[3]) * PW'(fx_b);
         py_ff[0] <= PW'(yd_ff[0]) * PW'(fe_low);
         py_ff[1] <= PW'(yd_ff[1]) * PW'(fe_high);
         py_ff[2] <= PW'(yd_ff[2]) * PW'(fx_a);
         py_ff[3] <= PW'(yd_ff[3]) * PW'(fx_b);

         node3_ff <= node2_ff;
         sxi3_ff  <= sxi2_ff;
         seta3_ff <= seta2_ff;
         dxx_ff   <= sxx[RS+DW-1:RS];
         dxe_ff   <= sxe[RS+DW-1:RS];
         dyx_ff   <= syx[RS+DW-1:RS];
         dye_ff   <= sye[RS+DW-1:RS];
         cxi_ff   <= cxi_in;
         ceta_ff  <= ceta_in;

         node4_ff <= node3_ff;
         sxi4_ff  <= sxi3_ff;
         seta4_ff <= seta3_ff;
         pj1_ff   <= pj1_full[WW-1:0];
         pj2_ff   <= pj2_full[WW-1:0];
         pnx1_ff  <= NW'(dye_ff) * NW'(cxi_ff);
         pnx2_ff  <= NW'(dyx_ff) * NW'(ceta_ff);
         pny1_ff  <= NW'(dxx_ff) * NW'(ceta_ff);
         pny2_ff  <= NW'(dxe_ff) * NW'(cxi_ff);

         front_ff.node  <= node4_ff;
         front_ff.shape <= shape_in;
         front_ff.jac   <= jr1 - jr2;
         front_ff.nx    <= WW'(nx_w);
         front_ff.ny    <= WW'(ny_w);
      end
   end

   assign front_word = front_ff;
endmodule

>>> src/quad_shape_function_jacobian.sv
`timescale 1ns / 1ps
// Bilinear quad element: per-node shape value, x/y derivatives and Jacobian at a Gauss point.
// Each accepted word (four Q16.16 corners and a Gauss point index) yields four result
// words, nodes 0..3 in order, the last flagged; a new word is taken only as the last node
// of the previous word moves on, set by the single result channel. The pipeline is an
// input holding register, 5 geometry stages, 33 divider stages (a setup stage, then one
// quotient bit per stage; two dividers for x and y) and the output register.
// A held result word stalls the whole pipeline, and the input while an earlier word is
// still being expanded into its nodes.
// A zero Jacobian flags degenerate and zeroes the derivatives.
module quad_shape_function_jacobian #(
   parameter int FRAC_BITS = qsfj_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_quad_point,
   input  logic signed [qsfj_pkg::COORD_W-1:0]  req_node_x0,
   input  logic signed [qsfj_pkg::COORD_W-1:0]  req_node_y0,
   input  logic signed [qsfj_pkg::COORD_W-1:0]  req_node_x1,
   input  logic signed [qsfj_pkg::COORD_W-1:0]  req_node_y1,
   input  logic signed [qsfj_pkg::COORD_W-1:0]  req_node_x2,
   input  logic signed [qsfj_pkg::COORD_W-1:0]  req_node_y2,
   input  logic signed [qsfj_pkg::COORD_W-1:0]  req_node_x3,
   input  logic signed [qsfj_pkg::COORD_W-1:0]  req_node_y3,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [qsfj_pkg::NODE_W-1:0]          rsp_node_index,
   output logic [qsfj_pkg::SHAPE_W-1:0]         rsp_shape_value,
   output logic signed [qsfj_pkg::DERIV_W-1:0]  rsp_deriv_x,
   output logic signed [qsfj_pkg::DERIV_W-1:0]  rsp_deriv_y,
   output logic signed [qsfj_pkg::JAC_W-1:0]    rsp_jacobian,
   output logic                                 rsp_degenerate,
   output logic                                 rsp_last
);
   localparam int DLAT = qsfj_pkg::QUO_W + 1;

   logic                         adv;
   qsfj_pkg::front_word_type     front_word;
   qsfj_pkg::side_type           side_ff [0:DLAT-1];
   logic [qsfj_pkg::QUO_W-1:0]   qx, qy;
   logic                         negx, negy, ovfx, ovfy;

   logic                         rsp_valid_ff;
   logic [qsfj_pkg::NODE_W-1:0]  node_ff;
   logic [qsfj_pkg::SHAPE_W-1:0] shape_ff;
   logic [qsfj_pkg::DERIV_W-1:0] dx_ff, dy_ff;
   logic [qsfj_pkg::JAC_W-1:0]   jac_ff;
   logic                         degen_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;

   qsfj_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_quad_point (req_quad_point),
      .req_node_x0    (req_node_x0),
      .req_node_y0    (req_node_y0),
      .req_node_x1    (req_node_x1),
      .req_node_y1    (req_node_y1),
      .req_node_x2    (req_node_x2),
      .req_node_y2    (req_node_y2),
      .req_node_x3    (req_node_x3),
      .req_node_y3    (req_node_y3),
      .front_word     (front_word)
   );

   qsfj_div u_div_x (
      .clock (clock),
      .adv   (adv),
      .num   (front_word.nx),
      .den   (front_word.jac <<< 2),
      .quot  (qx),
      .neg   (negx),
      .ovf   (ovfx)
   );

   qsfj_div u_div_y (
      .clock (clock),
      .adv   (adv),
      .num   (front_word.ny),
      .den   (front_word.jac <<< 2),
      .quot  (qy),
      .neg   (negy),
      .ovf   (ovfy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DLAT; k++) begin
            side_ff[k].valid <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         side_ff[0].valid <= front_word.valid;
         for (int k = 1; k < DLAT; k++) begin
            side_ff[k].valid <= side_ff[k-1].valid;
         end
         rsp_valid_ff <= side_ff[DLAT-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0].node  <= front_word.node;
         side_ff[0].shape <= front_word.shape;
         side_ff[0].jac   <= qsfj_pkg::sat_jac(front_word.jac);
         side_ff[0].degen <= front_word.jac == '0;
         for (int k = 1; k < DLAT; k++) begin
            side_ff[k].node  <= side_ff[k-1].node;
            side_ff[k].shape <= side_ff[k-1].shape;
            side_ff[k].jac   <= side_ff[k-1].jac;
            side_ff[k].degen <= side_ff[k-1].degen;
         end
         node_ff  <= side_ff[DLAT-1].node;
         shape_ff <= side_ff[DLAT-1].shape;
         jac_ff   <= side_ff[DLAT-1].jac;
         degen_ff <= side_ff[DLAT-1].degen;
         dx_ff    <= side_ff[DLAT-1].degen ? '0 : qsfj_pkg::sat_quot(qx, negx, ovfx);
         dy_ff    <= side_ff[DLAT-1].degen ? '0 : qsfj_pkg::sat_quot(qy, negy, ovfy);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_node_index  = node_ff;
   assign rsp_shape_value = shape_ff;
   assign rsp_deriv_x     = dx_ff;
   assign rsp_deriv_y     = dy_ff;
   assign rsp_jacobian    = jac_ff;
   assign rsp_degenerate  = degen_ff;
   assign rsp_last        = node_ff == qsfj_pkg::LAST_NODE;
endmodule

>>> src/qsfj_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result channel, bound to the top level.
module qsfj_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [qsfj_pkg::NODE_W-1:0]          rsp_node_index,
   input logic signed [qsfj_pkg::DERIV_W-1:0]  rsp_deriv_x,
   input logic signed [qsfj_pkg::DERIV_W-1:0]  rsp_deriv_y,
   input logic signed [qsfj_pkg::JAC_W-1:0]    rsp_jacobian,
   input logic                                 rsp_degenerate,
   input logic                                 rsp_last
);
   a_after_reset: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_node_index))
      else $error("stalled result word dropped or changed");

   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_deriv_x == '0 && rsp_deriv_y == '0 && rsp_jacobian == '0)
      else $error("degenerate word with nonzero derivative or Jacobian");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == (rsp_node_index == qsfj_pkg::LAST_NODE))
      else $error("last flag not on node 3");
endmodule

bind quad_shape_function_jacobian qsfj_checker u_qsfj_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_node_index (rsp_node_index),
   .rsp_deriv_x    (rsp_deriv_x),
   .rsp_deriv_y    (rsp_deriv_y),
   .rsp_jacobian   (rsp_jacobian),
   .rsp_degenerate (rsp_degenerate),
   .rsp_last       (rsp_last)
);
